// ===== rtl/core/rpn_alu_pkg.sv =====
// ============================================================================
// rpn_alu_pkg: shared types and constants for the RPN stack calculator
// Holds stack sizing, operation codes, status codes and cell control struct.
// ============================================================================
package rpn_alu_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DW          = 32;
	localparam int CW          = $clog2(STACK_DEPTH + 1);
	localparam int DIV_STEPS   = DW;
	localparam int DCW         = $clog2(DIV_STEPS + 1);

	localparam logic [4:0] F_PUSH = 5'd0;
	localparam logic [4:0] F_NOP  = 5'd1;
	localparam logic [4:0] F_PRT0 = 5'd2;
	localparam logic [4:0] F_PRT3 = 5'd5;
	localparam logic [4:0] F_OR   = 5'd6;
	localparam logic [4:0] F_XOR  = 5'd7;
	localparam logic [4:0] F_AND  = 5'd8;
	localparam logic [4:0] F_SHL  = 5'd9;
	localparam logic [4:0] F_SHR  = 5'd10;
	localparam logic [4:0] F_ADD  = 5'd11;
	localparam logic [4:0] F_SUB  = 5'd12;
	localparam logic [4:0] F_MUL  = 5'd13;
	localparam logic [4:0] F_DIV  = 5'd14;
	localparam logic [4:0] F_MOD  = 5'd15;
	localparam logic [4:0] F_NEG  = 5'd16;
	localparam logic [4:0] F_INV  = 5'd17;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNDER   = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_DIVZ    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	// Stack movement applied to the whole row of cells together
	typedef struct packed {
		logic push;     // shift everything down one cell, load top
		logic pop;      // shift everything up one cell, load top
		logic load;     // replace top cell only
	} cell_ctrl_t;

endpackage

// ===== rtl/core/rpn_alu_cell.sv =====
// ============================================================================
// rpn_alu_cell: one stack cell
// Holds one word; takes the word above on push, the word below on pop.
// ============================================================================
module rpn_alu_cell (
	input  logic                   clk,
	input  rpn_alu_pkg::cell_ctrl_t ctrl,
	input  logic                   is_top,
	input  logic [31:0]            top_in,
	input  logic [31:0]            from_up,
	input  logic [31:0]            from_down,
	output logic [31:0]            value
);
	import rpn_alu_pkg::*;

	logic [31:0] value_q;

	// Shift with the row, or load a new top
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			value_q <= is_top ? top_in : from_up;
		end else if (ctrl.pop) begin
			value_q <= is_top ? top_in : from_down;
		end else if (ctrl.load && is_top) begin
			value_q <= top_in;
		end
	end

	assign value = value_q;

endmodule

// ===== rtl/core/rpn_alu_divider.sv =====
// ============================================================================
// rpn_alu_divider: unsigned restoring divider
// Produces one quotient bit per cycle; quotient and remainder after 32 steps.
// ============================================================================
module rpn_alu_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [31:0] remainder
);
	import rpn_alu_pkg::*;

	logic [31:0]  quo_q;
	logic [31:0]  rem_q;
	logic [31:0]  dvs_q;
	logic [DCW-1:0] cnt_q;
	logic         busy_q;
	logic [32:0]  trial;
	logic [32:0]  shifted;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, dvs_q};

	// Iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCW'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done      = busy_q && (cnt_q == DCW'(1));
	assign quotient  = trial[32] ? {quo_q[30:0], 1'b0} : {quo_q[30:0], 1'b1};
	assign remainder = trial[32] ? shifted[31:0] : trial[31:0];

endmodule

// ===== rtl/core/rpn_stack_integer_alu_unit.sv =====
// ============================================================================
// rpn_stack_integer_alu_unit: 32-bit reverse-Polish stack calculator
// Stack is a row of shifting cells; top two cells feed the ALU.
// ============================================================================
// channel | dir | tdata fields (low bit up)              | tuser
// s_axis  | in  | func[4:0], push_value[36:5] (40 bits)   | -
// m_axis  | out | top_value[31:0], depth[36:32],          | -
//         |     | status[39:37] (40 bits)                 |
// Sequence: the input transfer is captured, the item executes (div and mod run
// the divider, which retires one quotient bit per cycle, in S_DIV), and the
// result is presented in S_OUT; the input opens in the cycle after the output
// transfer.
// Reset: stack empty, output empty. One item in flight at a time.
// A result waits in the output register until taken; the next item is
// accepted only once it has been taken.
module rpn_stack_integer_alu_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // func, push_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // top_value, depth, status
);
	import rpn_alu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t        state_q;
	logic [4:0]    func_q;
	logic [31:0]   pv_q;
	logic [CW-1:0] count_q;
	logic [31:0]   top_q;
	logic [CW-1:0] depth_q;
	logic [2:0]    status_q;
	logic          exec_q;

	logic [31:0]   cell_val [STACK_DEPTH];
	logic [31:0]   a;
	logic [31:0]   b;
	logic [31:0]   res;
	logic [31:0]   prod;
	cell_ctrl_t    ctrl;
	logic [31:0]   top_in;
	logic [2:0]    st;
	logic          div_start;
	logic          div_done;
	logic [31:0]   quo;
	logic [31:0]   rem;
	logic          is_div;
	logic          is_bin;

	// Cell 0 is the top of stack
	assign b = cell_val[0];
	assign a = cell_val[1];
	assign prod = a * b;
	assign is_div = (func_q == F_DIV) || (func_q == F_MOD);
	assign is_bin = (func_q >= F_OR) && (func_q <= F_MOD);

	// Decode status and ALU result for the held item
	always_comb begin
		st  = ST_OK;
		res = '0;
		case (func_q)
			F_OR:  res = a | b;
			F_XOR: res = a ^ b;
			F_AND: res = a & b;
			F_SHL: res = (b >= 32'd32) ? '0 : a << b[4:0];
			F_SHR: res = (b >= 32'd32) ? '0 : a >> b[4:0];
			F_ADD: res = a + b;
			F_SUB: res = a - b;
			F_MUL: res = prod;
			F_DIV: res = quo;
			F_MOD: res = rem;
			F_NEG: res = 32'd0 - b;
			F_INV: res = ~b;
			default: res = '0;
		endcase
		if (func_q == F_PUSH) begin
			if (count_q >= CW'(STACK_DEPTH)) st = ST_OVER;
		end else if (func_q == F_NOP) begin
			st = ST_OK;
		end else if (func_q <= F_PRT3) begin
			if (count_q == '0) st = ST_UNDER;
		end else if (is_bin) begin
			if (count_q < CW'(2)) st = ST_UNDER;
			else if (is_div && b == '0) st = ST_DIVZ;
		end else if (func_q <= F_INV) begin
			if (count_q == '0) st = ST_UNDER;
		end else begin
			st = ST_UNKNOWN;
		end
	end

	// Row movement: only on the commit cycle
	always_comb begin
		ctrl   = '0;
		top_in = res;
		div_start = exec_q && is_div && (st == ST_OK);
		if (st == ST_OK && ((exec_q && !is_div) || div_done)) begin
			if (func_q == F_PUSH) begin
				ctrl.push = 1'b1;
				top_in = pv_q;
			end else if (is_bin) begin
				ctrl.pop = 1'b1;
			end else if (func_q == F_NEG || func_q == F_INV) begin
				ctrl.load = 1'b1;
			end
		end
	end

	// Row of stack cells
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [31:0] up_v;
		logic [31:0] dn_v;
		if (i == 0) begin : g_t
			assign up_v = '0;
		end else begin : g_u
			assign up_v = cell_val[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_b
			assign dn_v = '0;
		end else begin : g_d
			assign dn_v = cell_val[i+1];
		end
		rpn_alu_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.is_top    (i == 0),
			.top_in    (top_in),
			.from_up   (up_v),
			.from_down (dn_v),
			.value     (cell_val[i])
		);
	end

	rpn_alu_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a),
		.divisor   (b),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign s_axis_tready = (state_q == S_IDLE) && !exec_q;
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {status_q, (5)'(depth_q), top_q};

	// Sequence one item: capture, execute (or divide), present result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exec_q  <= 1'b0;
			count_q <= '0;
		end else begin
			exec_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						exec_q <= 1'b1;
					end else if (exec_q) begin
						if (div_start) state_q <= S_DIV;
						else begin
							state_q <= S_OUT;
							if (st == ST_OK && func_q == F_PUSH) count_q <= count_q + 1'b1;
							if (st == ST_OK && is_bin) count_q <= count_q - 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
						count_q <= count_q - 1'b1;
					end
				end
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_q <= s_axis_tdata[4:0];
			pv_q   <= s_axis_tdata[36:5];
		end
		if ((exec_q && !div_start) || div_done) begin
			status_q <= st;
		end
	end

	// Top and depth are read combinationally from the cells and the count
	assign top_q   = (count_q == '0) ? '0 : cell_val[0];
	assign depth_q = count_q;

	// Checks
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH)) else $error("depth beyond stack");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider done outside divide");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> (count_q == $past(count_q))) else $error("stack moved");

endmodule

// ===== tb/rpn_stack_integer_alu_unit_tb.sv =====
// ============================================================================
// rpn_stack_integer_alu_unit_tb: self-checking bench for the RPN calculator
// Drives push and operation transfers, predicts top, depth and status of each
// result with a local stack model, and compares every output transfer.
// ============================================================================
`timescale 1ns / 100ps

module rpn_stack_integer_alu_unit_tb;
	import rpn_alu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // func[4:0], push_value[36:5]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // top_value[31:0], depth[36:32], status[39:37]

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  depth;
		logic [31:0] top_value;
	} calc_result_t;

	logic [31:0]  calc_stack [STACK_DEPTH];
	int           calc_depth;
	calc_result_t pending_results [$];
	int           send_idle_pct;
	int           recv_idle_pct;
	int           mismatches;

	rpn_stack_integer_alu_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// End a hung run
	initial begin
		#20ms;
		$display("FAIL rpn_stack_integer_alu_unit");
		$finish;
	end

	// Compute the result of one operation and update the local stack
	function automatic calc_result_t calc_step(logic [4:0] func, logic [31:0] value);
		calc_result_t r;
		logic [31:0] a, b, y;
		r.status = ST_OK;
		if (func == F_PUSH) begin
			if (calc_depth >= STACK_DEPTH) begin
				r.status = ST_OVER;
			end else begin
				calc_stack[calc_depth] = value;
				calc_depth++;
			end
		end else if (func == F_NOP) begin
			r.status = ST_OK;
		end else if (func <= F_PRT3) begin
			if (calc_depth == 0) r.status = ST_UNDER;
		end else if (func <= F_MOD) begin
			if (calc_depth < 2) begin
				r.status = ST_UNDER;
			end else begin
				b = calc_stack[calc_depth-1];
				a = calc_stack[calc_depth-2];
				if ((func == F_DIV || func == F_MOD) && b == 0) begin
					r.status = ST_DIVZ;
				end else begin
					case (func)
						F_OR:    y = a | b;
						F_XOR:   y = a ^ b;
						F_AND:   y = a & b;
						F_SHL:   y = (b >= 32) ? 32'd0 : a << b[4:0];
						F_SHR:   y = (b >= 32) ? 32'd0 : a >> b[4:0];
						F_ADD:   y = a + b;
						F_SUB:   y = a - b;
						F_MUL:   y = a * b;
						F_DIV:   y = a / b;
						default: y = a % b;
					endcase
					calc_stack[calc_depth-2] = y;
					calc_depth--;
				end
			end
		end else if (func <= F_INV) begin
			if (calc_depth == 0) begin
				r.status = ST_UNDER;
			end else begin
				a = calc_stack[calc_depth-1];
				calc_stack[calc_depth-1] = (func == F_NEG) ? -a : ~a;
			end
		end else begin
			r.status = ST_UNKNOWN;
		end
		r.top_value = (calc_depth == 0) ? 32'd0 : calc_stack[calc_depth-1];
		r.depth = calc_depth[4:0];
		return r;
	endfunction

	// Send one item; queue its prediction at the transfer edge
	task automatic send_item(logic [4:0] func, logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {value, func};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(calc_step(func, value));
		@(negedge clk);
	endtask

	// Check each output transfer against the oldest prediction
	always @(posedge clk) begin
		calc_result_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp top %h depth %0d st %0d, got top %h depth %0d st %0d",
							exp_r.top_value, exp_r.depth, exp_r.status,
							got.top_value, got.depth, got.status);
				end
			end
		end
	end

	// Random receiver stall
	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Drop the input and hold until every result has come
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic pop_all();
		while (calc_depth > 0) send_item(F_ADD, 0) ;
	endtask

	// Directed: edge values, every code, underflow and divide by zero
	task automatic test_directed();
		send_item(F_NOP, 32'hFFFF_FFFF);
		send_item(F_PRT0, 0);
		send_item(F_NEG, 0);
		send_item(F_ADD, 0);
		send_item(5'd31, 32'hFFFF_FFFF);
		send_item(F_PUSH, 32'hFFFF_FFFF);
		send_item(F_PUSH, 0);
		send_item(F_DIV, 0);
		send_item(F_MOD, 0);
		send_item(F_SHL, 0);
		send_item(F_PUSH, 32);
		send_item(F_SHR, 0);
		send_item(F_PUSH, 7);
		for (int f = F_PRT0; f <= F_INV; f++) begin
			send_item(F_PUSH, $urandom_range(40));
			send_item(f[4:0], 0);
		end
	endtask

	// Fill to overflow, then reduce back down
	task automatic test_overflow();
		while (calc_depth < STACK_DEPTH) send_item(F_PUSH, $urandom);
		send_item(F_PUSH, 32'hA5A5_A5A5);
		send_item(F_PRT3, 0);
		wait_drained();
		while (calc_depth > 1) send_item(F_XOR, 0);
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(4))
			0:       return $urandom_range(40);
			1:       return 0;
			2:       return 32'hFFFF_FFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	// Random mix: mostly well-formed operations, some noise codes
	task automatic test_random(int n);
		logic [4:0] f;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) f = 5'($urandom);
			else if (calc_depth < 2 || ($urandom_range(2) == 0 && calc_depth < STACK_DEPTH - 1))
				f = F_PUSH;
			else f = 5'($urandom_range(F_INV, F_NOP));
			send_item(f, (f == F_PUSH) ? rand_operand() : $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		calc_depth = 0;
		mismatches = 0;
		send_idle_pct = 10;
		recv_idle_pct = 76;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_overflow();
		test_random(350);
		send_idle_pct = 76;
		recv_idle_pct = 10;
		test_random(350);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(350);
		wait_drained();
		repeat (100) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS rpn_stack_integer_alu_unit");
		end else begin
			$display("FAIL rpn_stack_integer_alu_unit");
		end
		$finish;
	end

endmodule
